// ===== sv/dmc_pkg.sv =====
`default_nettype none

package dmc_pkg;

	// field widths fixed by the beat layout
	localparam int unsigned ADDR_IN_W = 16;
	localparam int unsigned TAG_W     = 16;
	localparam int unsigned LINE_W    = 8;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned CFG_W     = 4;
	localparam int unsigned RES_W     = 122;
	localparam int unsigned M_DATA_W  = 128;

	// largest index field the split can produce
	localparam int unsigned IDX_MAX   = 8;
	localparam int unsigned IDX_SPAN  = 256;

	// configuration register indexes
	localparam logic REG_OFFSET_BITS = 1'b0;
	localparam logic REG_INDEX_BITS  = 1'b1;

	localparam logic [CFG_W-1:0] OFFSET_RST = 4'd2;
	localparam logic [CFG_W-1:0] INDEX_RST  = 4'd3;

	// opcodes carried on tuser
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0]  replace_count;
		logic [CNT_W-1:0]  miss_count;
		logic [CNT_W-1:0]  hit_count;
		logic [LINE_W-1:0] line_index;
		logic [TAG_W-1:0]  old_tag;
		logic              replaced;
		logic              hit;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/dmc_ram.sv =====
`default_nettype none

module dmc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read returns the old word on a same-address write
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/direct_mapped_cache_tag_check.sv =====
`default_nettype none

// channel   | direction | signals                        | contents
// ----------+-----------+--------------------------------+------------------------------------
// s         | in        | s_tvalid s_tready s_tdata s_tuser | address on tdata, opcode on tuser
// m         | out       | m_tvalid m_tready m_tdata      | hit, replaced, old tag, line, counts
// cfg       | in        | cfg_we cfg_index cfg_wdata     | offset_bits (0), index_bits (1)
//
// one beat accepted per cycle while the output is not stalled; a result leaves through the output register
// after the registered read of the tag ram in stage 1 and the compare and
// counter update stage, which writes the new tag back in the same cycle
// reset clears the valid bits, counters and pipeline at once; no clearing pass is needed
// a stalled output holds the whole pipe, tag ram read included, so nothing is lost

module direct_mapped_cache_tag_check #(
	parameter int unsigned ADDR_WIDTH = 16,
	parameter int unsigned MAX_LINES  = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,    // [15:0] address
	input  wire logic [0:0]   s_tuser,    // [0] opcode

	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [0] hit, [1] replaced, [17:2] old_tag, [25:18] line_index,
	// [57:26] hit_count, [89:58] miss_count, [121:90] replace_count, rest zero
	output logic [127:0]      m_tdata,

	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [3:0]   cfg_wdata
);

	// only the first 256 lines can ever be indexed
	localparam int unsigned USED_LINES = (MAX_LINES < dmc_pkg::IDX_SPAN) ?
		MAX_LINES : dmc_pkg::IDX_SPAN;
	localparam int unsigned LW = (USED_LINES > 1) ? $clog2(USED_LINES) : 1;
	localparam logic [5:0] AW6 = 6'(ADDR_WIDTH);
	localparam logic [dmc_pkg::ADDR_IN_W-1:0] ADDR_MASK =
		(ADDR_WIDTH >= dmc_pkg::ADDR_IN_W) ? '1 :
		dmc_pkg::ADDR_IN_W'((33'd1 << ADDR_WIDTH) - 33'd1);
	localparam logic [5:0] IDX_CAP = 6'(dmc_pkg::IDX_MAX);

	// configuration registers
	logic [dmc_pkg::CFG_W-1:0] offset_q;
	logic [dmc_pkg::CFG_W-1:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= dmc_pkg::OFFSET_RST;
			index_q  <= dmc_pkg::INDEX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmc_pkg::REG_OFFSET_BITS: offset_q <= cfg_wdata;
				dmc_pkg::REG_INDEX_BITS:  index_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance: the output slot is free or being drained
	logic out_valid_q;
	logic en;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// address split on the incoming beat
	logic [dmc_pkg::ADDR_IN_W-1:0] in_addr;
	logic [5:0]                    off_c;
	logic [5:0]                    idx_c;
	logic [5:0]                    room;
	logic [dmc_pkg::LINE_W-1:0]    idx_mask;
	logic [dmc_pkg::LINE_W-1:0]    raw_idx;
	logic [dmc_pkg::TAG_W-1:0]     in_tag;
	logic [LW-1:0]                 in_line;
	logic [LW-1:0]                 mod_tbl [dmc_pkg::IDX_SPAN];

	// index wraps modulo the line count, small constant table
	for (genvar g = 0; g < dmc_pkg::IDX_SPAN; g++) begin : g_mod
		assign mod_tbl[g] = LW'(g % MAX_LINES);
	end

	always_comb begin
		in_addr = s_tdata & ADDR_MASK;
		// clamp offset to 8 and to the address width
		off_c = (offset_q > 4'd8) ? IDX_CAP : {2'b00, offset_q};
		if (off_c > AW6) begin
			off_c = AW6;
		end
		// clamp index to 8 and to what the offset leaves over
		idx_c = (index_q > 4'd8) ? IDX_CAP : {2'b00, index_q};
		room  = AW6 - off_c;
		if (idx_c > room) begin
			idx_c = room;
		end
		idx_mask = dmc_pkg::LINE_W'((9'd1 << idx_c) - 9'd1);
		raw_idx  = dmc_pkg::LINE_W'(in_addr >> off_c) & idx_mask;
		in_tag   = in_addr >> (off_c + idx_c);
		in_line  = mod_tbl[raw_idx];
	end

	// stage 1: beat registered while the tag ram is read
	logic                      v_s1;
	logic                      op_s1;
	logic [LW-1:0]             line_s1;
	logic [dmc_pkg::TAG_W-1:0] tag_s1;
	logic                      fwd_s1;
	logic [dmc_pkg::TAG_W-1:0] fwd_tag_s1;

	logic                      ram_we;
	logic [dmc_pkg::TAG_W-1:0] ram_rdata;

	// tag is written back when the stage 1 access moves on
	assign ram_we = en && v_s1 && (op_s1 == dmc_pkg::OP_ACCESS);

	dmc_ram #(
		.WIDTH (dmc_pkg::TAG_W),
		.DEPTH (USED_LINES)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (line_s1),
		.wdata (tag_s1),
		.re    (en),
		.raddr (in_line),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= s_tvalid;
			// same line written in this cycle: ram returns the stale tag
			fwd_s1 <= ram_we && (line_s1 == in_line);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= s_tuser[0];
			line_s1    <= in_line;
			tag_s1     <= in_tag;
			fwd_tag_s1 <= tag_s1;
		end
	end

	// tag compare and bookkeeping
	logic [USED_LINES-1:0]     valid_q;
	logic [dmc_pkg::CNT_W-1:0] hits_q;
	logic [dmc_pkg::CNT_W-1:0] misses_q;
	logic [dmc_pkg::CNT_W-1:0] replaces_q;

	logic [dmc_pkg::TAG_W-1:0] stored_tag;
	logic                      is_access;
	logic                      line_v;
	logic                      hit;
	logic                      replaced;
	logic [dmc_pkg::CNT_W-1:0] hits_nx;
	logic [dmc_pkg::CNT_W-1:0] misses_nx;
	logic [dmc_pkg::CNT_W-1:0] replaces_nx;
	dmc_pkg::result_t          res;

	always_comb begin
		stored_tag = fwd_s1 ? fwd_tag_s1 : ram_rdata;
		is_access  = (op_s1 == dmc_pkg::OP_ACCESS);
		line_v     = valid_q[line_s1];
		hit        = is_access && line_v && (stored_tag == tag_s1);
		replaced   = is_access && line_v && (stored_tag != tag_s1);

		hits_nx     = hits_q;
		misses_nx   = misses_q;
		replaces_nx = replaces_q;
		if (!is_access) begin
			hits_nx     = '0;
			misses_nx   = '0;
			replaces_nx = '0;
		end else if (hit) begin
			// saturating counts
			hits_nx = (hits_q == '1) ? hits_q : hits_q + 32'd1;
		end else begin
			misses_nx = (misses_q == '1) ? misses_q : misses_q + 32'd1;
			if (replaced) begin
				replaces_nx = (replaces_q == '1) ? replaces_q : replaces_q + 32'd1;
			end
		end

		res.hit           = hit;
		res.replaced      = replaced;
		res.old_tag       = replaced ? stored_tag : '0;
		res.line_index    = is_access ? dmc_pkg::LINE_W'(line_s1) : '0;
		res.hit_count     = hits_nx;
		res.miss_count    = misses_nx;
		res.replace_count = replaces_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			replaces_q <= '0;
		end else if (en && v_s1) begin
			hits_q     <= hits_nx;
			misses_q   <= misses_nx;
			replaces_q <= replaces_nx;
			if (is_access) begin
				valid_q[line_s1] <= 1'b1;
			end else begin
				// clear invalidates every line at once
				valid_q <= '0;
			end
		end
	end

	// output register
	dmc_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(dmc_pkg::M_DATA_W - dmc_pkg::RES_W){1'b0}}, res_q};

endmodule

`default_nettype wire
